### rtl/core/tfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the TLV frame deframer.
// No dependencies; the front, queue, back and top-level files refer to it by scoped names.
package tfd_pkg;

    localparam int HDR_BYTES      = 10;
    localparam int ATTR_HDR_BYTES = 6;
    localparam int QDEPTH         = 4;
    localparam int QAW            = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW            = $clog2(QDEPTH + 1);

    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_MISMATCH     = 3'd2,
        ST_BAD_ATTR_LEN = 3'd3,
        ST_TRUNC_HDR    = 3'd4
    } t_status;

    typedef struct packed {
        logic        has_value;
        logic        has_summary;
        logic [15:0] attr_type;
        logic [15:0] attr_reserved;
        logic [7:0]  value_byte;
        logic        value_last;
        logic [15:0] value_index;
        logic [15:0] hdr_version;
        logic [15:0] hdr_message_id;
        logic [31:0] hdr_vendor;
        logic [15:0] hdr_total_length;
        t_status     status;
    } t_entry;

    typedef struct packed {
        logic        kind;
        logic [15:0] attr_type;
        logic [15:0] attr_reserved;
        logic [7:0]  value_byte;
        logic        value_last;
        logic [15:0] value_index;
        logic [15:0] hdr_version;
        logic [15:0] hdr_message_id;
        logic [31:0] hdr_vendor;
        logic [15:0] hdr_total_length;
        logic [2:0]  frame_status;
        logic        run_last;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### rtl/core/tfd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the deframer byte input and result output.
// Depends on nothing; used by the front, back and top-level modules.
interface tfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source(output valid, data_byte, frame_end, input ready);
    modport sink(input valid, data_byte, frame_end, output ready);
endinterface

interface tfd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] attr_type;
    logic [15:0] attr_reserved;
    logic [7:0]  value_byte;
    logic        value_last;
    logic [15:0] value_index;
    logic [15:0] hdr_version;
    logic [15:0] hdr_message_id;
    logic [31:0] hdr_vendor;
    logic [15:0] hdr_total_length;
    logic [2:0]  frame_status;
    logic        run_last;

    modport source(output valid, kind, attr_type, attr_reserved, value_byte, value_last,
                   value_index, hdr_version, hdr_message_id, hdr_vendor, hdr_total_length,
                   frame_status, run_last, input ready);
    modport sink(input valid, kind, attr_type, attr_reserved, value_byte, value_last,
                 value_index, hdr_version, hdr_message_id, hdr_vendor, hdr_total_length,
                 frame_status, run_last, output ready);
endinterface

### rtl/core/tlv_frame_deframer_unit.sv
`timescale 1ns / 1ps
// Top level of the TLV frame deframer: front parser, work queue, result stage.
// Depends on tfd_pkg, tfd_if, tfd_front, tfd_queue and tfd_back.
//
// Usage:
//   i_in carries one frame byte per transaction with frame_end on the last
//   byte. o_out carries results: one per attribute value byte (kind 0), and
//   one frame summary (kind 1) on the frame-end byte, after its value result
//   if it has one. run_last marks the last result of each input byte.
//   Throughput is one byte per cycle while the queue is not full; the
//   frame-end byte that also carries a value byte yields two results in turn,
//   absorbed by the four-entry queue. An accepted byte is written into the
//   queue, and its first result is then loaded from the queue head into the
//   output register. Header and attribute-header bytes produce no results.
//   Reset clears the parser to the start of a frame and empties the queue and
//   output register. When the receiver stalls, the output register holds its
//   transaction, the queue fills, and i_in.ready drops once it is full.
module tlv_frame_deframer_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfd_in_if.sink    i_in,
    tfd_out_if.source o_out
);

    logic             push;
    logic             pop;
    tfd_pkg::t_entry  entry;
    tfd_pkg::t_entry  head;
    tfd_pkg::t_q_stat q_stat;

    tfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_entry  (entry)
    );

    tfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    tfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

### rtl/core/tfd_front.sv
`timescale 1ns / 1ps
// Front end: accepts frame bytes, tracks header and attribute parsing, and
// pushes one work entry per byte that yields results. Uses tfd_pkg, tfd_in_if.
module tfd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tfd_in_if.sink          i_in,
    input  tfd_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output tfd_pkg::t_entry o_entry
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ATTR_HEADER,
        PH_VALUE,
        PH_DISCARD
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [15:0]      r_pos, n_pos;
    logic [15:0]      r_version, n_version;
    logic [15:0]      r_msg_id, n_msg_id;
    logic [31:0]      r_vendor, n_vendor;
    logic [15:0]      r_total, n_total;
    logic [47:0]      r_shift, n_shift;
    logic [2:0]       r_hcnt, n_hcnt;
    logic [15:0]      r_rem, n_rem;
    logic [15:0]      r_vidx, n_vidx;
    logic [15:0]      r_bound, n_bound;
    tfd_pkg::t_status r_err, n_err;

    logic        accept;
    logic [7:0]  b;
    logic [47:0] sh;
    logic [15:0] hlen;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;
    assign sh         = {r_shift[39:0], b};
    assign hlen       = sh[31:16];

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_version = r_version;
        n_msg_id  = r_msg_id;
        n_vendor  = r_vendor;
        n_total   = r_total;
        n_shift   = r_shift;
        n_hcnt    = r_hcnt;
        n_rem     = r_rem;
        n_vidx    = r_vidx;
        n_bound   = r_bound;
        n_err     = r_err;
        o_entry   = '0;

        if (r_pos != 16'hFFFF) begin
            n_pos = r_pos + 16'd1;
        end

        case (r_phase)
            PH_HEADER: begin
                if (r_pos < 16'd2) begin
                    n_version = {r_version[7:0], b};
                end else if (r_pos < 16'd4) begin
                    n_msg_id = {r_msg_id[7:0], b};
                end else if (r_pos < 16'd8) begin
                    n_vendor = {r_vendor[23:0], b};
                end else begin
                    n_total = {r_total[7:0], b};
                end
                if (r_pos >= 16'(tfd_pkg::HDR_BYTES - 1)) begin
                    n_phase = PH_ATTR_HEADER;
                end
            end
            PH_ATTR_HEADER: begin
                n_shift = sh;
                n_hcnt  = r_hcnt + 3'd1;
                if (r_hcnt == 3'(tfd_pkg::ATTR_HDR_BYTES - 1)) begin
                    n_hcnt = '0;
                    if (hlen < 16'(tfd_pkg::ATTR_HDR_BYTES)) begin
                        n_err   = tfd_pkg::ST_BAD_ATTR_LEN;
                        n_phase = PH_DISCARD;
                    end else begin
                        n_bound = r_bound + hlen;
                        n_rem   = hlen - 16'(tfd_pkg::ATTR_HDR_BYTES);
                        n_vidx  = '0;
                        if (hlen != 16'(tfd_pkg::ATTR_HDR_BYTES)) begin
                            n_phase = PH_VALUE;
                        end
                    end
                end
            end
            PH_VALUE: begin
                o_entry.has_value     = 1'b1;
                o_entry.attr_type     = r_shift[15:0];
                o_entry.attr_reserved = r_shift[47:32];
                o_entry.value_byte    = b;
                o_entry.value_last    = (r_rem == 16'd1);
                o_entry.value_index   = r_vidx;
                n_rem  = r_rem - 16'd1;
                n_vidx = r_vidx + 16'd1;
                if (r_rem == 16'd1) begin
                    n_phase = PH_ATTR_HEADER;
                end
            end
            default: begin
            end
        endcase

        if (i_in.frame_end) begin
            o_entry.has_summary      = 1'b1;
            o_entry.hdr_version      = n_version;
            o_entry.hdr_message_id   = n_msg_id;
            o_entry.hdr_vendor       = n_vendor;
            o_entry.hdr_total_length = n_total;
            if (r_pos < 16'(tfd_pkg::HDR_BYTES - 1)) begin
                o_entry.status = tfd_pkg::ST_SHORT;
            end else if (n_err != tfd_pkg::ST_OK) begin
                o_entry.status = n_err;
            end else if (n_phase == PH_ATTR_HEADER && n_hcnt != 3'd0) begin
                o_entry.status = tfd_pkg::ST_TRUNC_HDR;
            end else if (n_bound != n_total) begin
                o_entry.status = tfd_pkg::ST_MISMATCH;
            end else begin
                o_entry.status = tfd_pkg::ST_OK;
            end
            n_phase   = PH_HEADER;
            n_pos     = '0;
            n_version = '0;
            n_msg_id  = '0;
            n_vendor  = '0;
            n_total   = '0;
            n_shift   = '0;
            n_hcnt    = '0;
            n_rem     = '0;
            n_vidx    = '0;
            n_bound   = 16'(tfd_pkg::HDR_BYTES);
            n_err     = tfd_pkg::ST_OK;
        end
    end

    assign o_push = accept && (o_entry.has_value || o_entry.has_summary);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_pos     <= '0;
            r_version <= '0;
            r_msg_id  <= '0;
            r_vendor  <= '0;
            r_total   <= '0;
            r_shift   <= '0;
            r_hcnt    <= '0;
            r_rem     <= '0;
            r_vidx    <= '0;
            r_bound   <= 16'(tfd_pkg::HDR_BYTES);
            r_err     <= tfd_pkg::ST_OK;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_version <= n_version;
            r_msg_id  <= n_msg_id;
            r_vendor  <= n_vendor;
            r_total   <= n_total;
            r_shift   <= n_shift;
            r_hcnt    <= n_hcnt;
            r_rem     <= n_rem;
            r_vidx    <= n_vidx;
            r_bound   <= n_bound;
            r_err     <= n_err;
        end
    end

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.frame_end |=> r_phase == PH_HEADER && r_pos == 16'd0 &&
            r_bound == 16'(tfd_pkg::HDR_BYTES))
        else $error("state not cleared after frame end");

    a_value_pushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_phase == PH_VALUE |-> o_push && o_entry.has_value)
        else $error("value byte not pushed");

endmodule

### rtl/core/tfd_queue.sv
`timescale 1ns / 1ps
// Short work queue between the deframer front and back ends.
// Uses tfd_pkg for the entry type and depth.
module tfd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tfd_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output tfd_pkg::t_entry  o_head,
    output tfd_pkg::t_q_stat o_stat
);

    tfd_pkg::t_entry            r_mem [tfd_pkg::QDEPTH];
    logic [tfd_pkg::QAW-1:0]    r_wr, r_rd;
    logic [tfd_pkg::QCW-1:0]    r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == tfd_pkg::QCW'(tfd_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == tfd_pkg::QAW'(tfd_pkg::QDEPTH - 1)) ? '0 :
                        r_wr + tfd_pkg::QAW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == tfd_pkg::QAW'(tfd_pkg::QDEPTH - 1)) ? '0 :
                        r_rd + tfd_pkg::QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + tfd_pkg::QCW'(1);
                2'b01:   r_cnt <= r_cnt - tfd_pkg::QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

endmodule

### rtl/core/tfd_back.sv
`timescale 1ns / 1ps
// Back end: expands queued entries into value and summary results and holds
// them in the output register. Uses tfd_pkg, tfd_out_if.
module tfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tfd_pkg::t_entry  i_head,
    input  tfd_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    tfd_out_if.source        o_out
);

    logic              r_valid, n_valid;
    logic              r_second, n_second;
    tfd_pkg::t_result  r_res, n_res;
    logic              load;

    assign load = !r_valid || o_out.ready;

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_res    = r_res;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = !i_q_stat.empty;
            n_res   = '0;
            if (!i_q_stat.empty) begin
                if (i_head.has_value && !r_second) begin
                    n_res.kind          = tfd_pkg::KIND_VALUE;
                    n_res.attr_type     = i_head.attr_type;
                    n_res.attr_reserved = i_head.attr_reserved;
                    n_res.value_byte    = i_head.value_byte;
                    n_res.value_last    = i_head.value_last;
                    n_res.value_index   = i_head.value_index;
                    n_res.run_last      = !i_head.has_summary;
                    n_second            = i_head.has_summary;
                    o_pop               = !i_head.has_summary;
                end else begin
                    n_res.kind             = tfd_pkg::KIND_SUMMARY;
                    n_res.hdr_version      = i_head.hdr_version;
                    n_res.hdr_message_id   = i_head.hdr_message_id;
                    n_res.hdr_vendor       = i_head.hdr_vendor;
                    n_res.hdr_total_length = i_head.hdr_total_length;
                    n_res.frame_status     = i_head.status;
                    n_res.run_last         = 1'b1;
                    n_second               = 1'b0;
                    o_pop                  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
        r_res <= n_res;
    end

    assign o_out.valid            = r_valid;
    assign o_out.kind             = r_res.kind;
    assign o_out.attr_type        = r_res.attr_type;
    assign o_out.attr_reserved    = r_res.attr_reserved;
    assign o_out.value_byte       = r_res.value_byte;
    assign o_out.value_last       = r_res.value_last;
    assign o_out.value_index      = r_res.value_index;
    assign o_out.hdr_version      = r_res.hdr_version;
    assign o_out.hdr_message_id   = r_res.hdr_message_id;
    assign o_out.hdr_vendor       = r_res.hdr_vendor;
    assign o_out.hdr_total_length = r_res.hdr_total_length;
    assign o_out.frame_status     = r_res.frame_status;
    assign o_out.run_last         = r_res.run_last;

    a_second_has_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> !i_q_stat.empty && i_head.has_summary)
        else $error("summary pending without queued summary");

endmodule
